>>> hw/rtl/vofm_pkg.sv
package vofm_pkg;

    // command codes carried in tuser of the input stream
    localparam logic CMD_CELL  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // register indexes of the configuration port
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_SELECT_COLOR    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERFACE_COLOR = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_X          = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Y          = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Z          = 3'd4;
    localparam int CFG_DATA_W = 16;

    // field widths
    localparam int COLOR_W     = 16;
    localparam int SIZE_X_W    = 7;
    localparam int SIZE_Y_W    = 7;
    localparam int SIZE_Z_W    = 13;
    localparam int CELL_X_W    = 6;
    localparam int CELL_Y_W    = 6;
    localparam int CELL_Z_W    = 12;
    localparam int FACE_W      = 6;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 48;
    localparam int M_TDATA_PAD = M_TDATA_W - (CELL_X_W + CELL_Y_W + CELL_Z_W + FACE_W + COLOR_W);

    // size registers after reset
    localparam int SIZE_X_RST = 64;
    localparam int SIZE_Y_RST = 64;
    localparam int SIZE_Z_RST = 4096;

    // each history word keeps three consecutive planes, indexed by plane number mod 3
    localparam int LVL_N = 3;
    typedef logic [1:0] t_lvl;
    typedef logic [LVL_N-1:0] t_lvl_word;

    localparam t_lvl LVL_0 = 2'd0;
    localparam t_lvl LVL_1 = 2'd1;
    localparam t_lvl LVL_2 = 2'd2;

    function automatic t_lvl lvl_next(input t_lvl l);
        t_lvl r;
        unique case (l)
            LVL_0:   r = LVL_1;
            LVL_1:   r = LVL_2;
            default: r = LVL_0;
        endcase
        return r;
    endfunction

    function automatic t_lvl lvl_prev(input t_lvl l);
        t_lvl r;
        unique case (l)
            LVL_1:   r = LVL_0;
            LVL_2:   r = LVL_1;
            default: r = LVL_2;
        endcase
        return r;
    endfunction

    function automatic t_lvl_word lvl_onehot(input t_lvl l);
        t_lvl_word r;
        unique case (l)
            LVL_1:   r = 3'b010;
            LVL_2:   r = 3'b100;
            default: r = 3'b001;
        endcase
        return r;
    endfunction

    function automatic logic lvl_pick(input t_lvl_word w, input t_lvl l);
        return |(w & lvl_onehot(l));
    endfunction

    // replace one level of a word with a bit that was written in the same cycle
    function automatic t_lvl_word lvl_merge(input t_lvl_word w, input logic hit,
                                            input t_lvl l, input logic b);
        t_lvl_word m;
        m = lvl_onehot(l);
        return hit ? ((w & ~m) | (b ? m : '0)) : w;
    endfunction

endpackage

>>> hw/rtl/voxel_outer_face_marker.sv
// channel   | direction | fields (tdata / tuser / tlast)
// ----------+-----------+-------------------------------------------------------------
// s_axis    | in        | color_value / cmd / -
// m_axis    | out       | cell_x, cell_y, cell_z, face_mask, mark_color / cell_selected
//           |           | / last
// cfg       | in        | index 0..4: select_color, interface_color, size_x/y/z
//
// one item per cycle while s_axis_tready is high; an item that causes a result loads the
// memory read and mask stage registers, whose mask logic then fills the output register
// the history memory gives one write and two reads per copy each cycle, which sets the rate
// in the cycle after any config write the input is held off while the plane size settles
// reset clears counters and control only; the history memory needs no clearing pass
// s_axis_tready falls in that hold cycle, or when the mask stage and the output register
// are both full and m_axis_tready is low
module voxel_outer_face_marker #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [vofm_pkg::S_TDATA_W-1:0]         s_axis_tdata,  // [15:0] color_value
    input  logic                                   s_axis_tuser,  // [0] cmd

    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [5:0] cell_x, [11:6] cell_y, [23:12] cell_z, [29:24] face_mask,
    // [45:30] mark_color, [47:46] zero
    output logic [vofm_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    output logic                                   m_axis_tuser,  // [0] cell_selected
    output logic                                   m_axis_tlast,  // last

    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [vofm_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [vofm_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int XW    = $clog2(MAX_X + 1);
    localparam int YW    = $clog2(MAX_Y + 1);
    localparam int ZW    = $clog2(MAX_Z + 1);
    localparam int PLANE = MAX_X * MAX_Y;
    localparam int SW    = $clog2(PLANE);
    localparam int PW    = $clog2(PLANE + 1);

    localparam int EX_RST = (vofm_pkg::SIZE_X_RST > MAX_X) ? MAX_X : vofm_pkg::SIZE_X_RST;
    localparam int EY_RST = (vofm_pkg::SIZE_Y_RST > MAX_Y) ? MAX_Y : vofm_pkg::SIZE_Y_RST;
    localparam int EZ_RST = (vofm_pkg::SIZE_Z_RST > MAX_Z) ? MAX_Z : vofm_pkg::SIZE_Z_RST;

    // zero counts as one, anything above the maximum as the maximum
    function automatic int clamp_size(input int v, input int max_v);
        int r;
        if (v == 0) begin
            r = 1;
        end else if (v > max_v) begin
            r = max_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // configuration
    logic [vofm_pkg::COLOR_W-1:0] r_select_color;
    logic [vofm_pkg::COLOR_W-1:0] r_interface_color;
    logic [XW-1:0]                r_ex;
    logic [YW-1:0]                r_ey;
    logic [ZW-1:0]                r_ez;
    logic [PW-1:0]                r_plane;
    logic                         r_cfg_hold;

    // stream position
    logic [SW-1:0]          r_in_slot,  n_in_slot;
    vofm_pkg::t_lvl         r_in_lvl,   n_in_lvl;
    logic [XW-1:0]          r_out_x,    n_out_x;
    logic [YW-1:0]          r_out_y,    n_out_y;
    logic [ZW-1:0]          r_out_z,    n_out_z;
    logic [SW-1:0]          r_out_slot, n_out_slot;
    vofm_pkg::t_lvl         r_out_lvl,  n_out_lvl;
    logic [PW-1:0]          r_pending,  n_pending;

    // mask stage, fed by the memory read
    logic                   r_s2_valid;
    logic [XW-1:0]          r_s2_x;
    logic [YW-1:0]          r_s2_y;
    logic [ZW-1:0]          r_s2_z;
    vofm_pkg::t_lvl         r_s2_lvl;
    logic [5:0]             r_s2_force;
    logic                   r_s2_last;
    logic [3:0]             r_s2_fwd;
    vofm_pkg::t_lvl         r_s2_wlvl;
    logic                   r_s2_wbit;
    logic                   r_prev_sel;

    // output register
    logic                          r_m_valid;
    logic [vofm_pkg::M_TDATA_W-1:0] r_m_data;
    logic                          r_m_sel;
    logic                          r_m_last;

    logic cfg_acc;
    logic in_acc;
    logic is_cell;
    logic emit;
    logic wr_en;
    logic wr_bit;
    logic adv;
    logic in_end;
    logic x_end, y_end, z_end, slot_end;

    logic [SW-1:0] addr_c, addr_xp, addr_ym, addr_yp;
    logic [3:0]    s1_fwd;
    logic [5:0]    s1_force;
    logic          s1_last;
    logic          arr_x, arr_y, arr_z;

    vofm_pkg::t_lvl_word rd_c, rd_xp, rd_ym, rd_yp;
    vofm_pkg::t_lvl_word w_c, w_xp, w_ym, w_yp;
    logic          s2_sel;
    logic [5:0]    s2_nb;
    logic [5:0]    s2_face;
    logic [vofm_pkg::COLOR_W-1:0] s2_mark;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // the mask stage moves on when the output register is empty or being taken
    assign adv           = !r_m_valid || m_axis_tready;
    assign s_axis_tready = !r_cfg_hold && (!r_s2_valid || adv);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_cell       = (s_axis_tuser == vofm_pkg::CMD_CELL);

    // a cell emits once the plane behind it is full, a flush whenever anything is pending
    assign emit   = in_acc && (is_cell ? (r_pending == r_plane) : (r_pending != '0));
    assign wr_en  = in_acc && is_cell;
    assign wr_bit = (s_axis_tdata[vofm_pkg::COLOR_W-1:0] == r_select_color);

    assign in_end   = (PW'(r_in_slot) == r_plane - PW'(1));
    assign x_end    = (r_out_x == r_ex - XW'(1));
    assign y_end    = (r_out_y == r_ey - YW'(1));
    assign z_end    = (r_out_z == r_ez - ZW'(1));
    assign slot_end = (PW'(r_out_slot) == r_plane - PW'(1));

    // neighbor slots of the cell being reported
    assign addr_c  = r_out_slot;
    assign addr_xp = r_out_slot + SW'(1);
    assign addr_ym = r_out_slot - SW'(r_ex);
    assign addr_yp = r_out_slot + SW'(r_ex);

    // same-cycle write goes around the memory
    assign s1_fwd[0] = wr_en && (r_in_slot == addr_c);
    assign s1_fwd[1] = wr_en && (r_in_slot == addr_xp);
    assign s1_fwd[2] = wr_en && (r_in_slot == addr_ym);
    assign s1_fwd[3] = wr_en && (r_in_slot == addr_yp);

    // has the +x, +y, +z neighbor arrived yet
    assign arr_x = is_cell || (r_pending > PW'(1));
    assign arr_y = is_cell || (r_pending > PW'(r_ex));
    assign arr_z = is_cell;

    assign s1_force[0] = (r_out_x == '0);
    assign s1_force[1] = (r_out_y == '0);
    assign s1_force[2] = (r_out_z == '0);
    assign s1_force[3] = x_end || !arr_x;
    assign s1_force[4] = y_end || !arr_y;
    assign s1_force[5] = z_end || !arr_z;
    assign s1_last     = x_end && y_end && z_end;

    always_comb begin
        n_in_slot  = r_in_slot;
        n_in_lvl   = r_in_lvl;
        n_out_x    = r_out_x;
        n_out_y    = r_out_y;
        n_out_z    = r_out_z;
        n_out_slot = r_out_slot;
        n_out_lvl  = r_out_lvl;
        n_pending  = r_pending;

        if (wr_en) begin
            if (in_end) begin
                n_in_slot = '0;
                n_in_lvl  = vofm_pkg::lvl_next(r_in_lvl);
            end else begin
                n_in_slot = r_in_slot + SW'(1);
            end
        end

        if (emit) begin
            if (x_end) begin
                n_out_x = '0;
                if (y_end) begin
                    n_out_y = '0;
                    n_out_z = z_end ? '0 : r_out_z + ZW'(1);
                end else begin
                    n_out_y = r_out_y + YW'(1);
                end
            end else begin
                n_out_x = r_out_x + XW'(1);
            end
            if (slot_end) begin
                n_out_slot = '0;
                n_out_lvl  = vofm_pkg::lvl_next(r_out_lvl);
            end else begin
                n_out_slot = r_out_slot + SW'(1);
            end
        end

        // pending stays full on a cell that emits
        if (wr_en && !emit) begin
            n_pending = r_pending + PW'(1);
        end else if (emit && !is_cell) begin
            n_pending = r_pending - PW'(1);
        end

        // a size write restarts the stream
        if (cfg_acc && (i_cfg_index == vofm_pkg::REG_SIZE_X ||
                        i_cfg_index == vofm_pkg::REG_SIZE_Y ||
                        i_cfg_index == vofm_pkg::REG_SIZE_Z)) begin
            n_in_slot  = '0;
            n_in_lvl   = vofm_pkg::LVL_0;
            n_out_x    = '0;
            n_out_y    = '0;
            n_out_z    = '0;
            n_out_slot = '0;
            n_out_lvl  = vofm_pkg::LVL_0;
            n_pending  = '0;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select_color    <= '0;
            r_interface_color <= '0;
            r_ex              <= XW'(EX_RST);
            r_ey              <= YW'(EY_RST);
            r_ez              <= ZW'(EZ_RST);
            r_plane           <= PW'(EX_RST * EY_RST);
            r_cfg_hold        <= 1'b0;
        end else begin
            r_cfg_hold <= cfg_acc;
            r_plane    <= PW'(r_ex) * PW'(r_ey);
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    vofm_pkg::REG_SELECT_COLOR:    r_select_color    <= i_cfg_data;
                    vofm_pkg::REG_INTERFACE_COLOR: r_interface_color <= i_cfg_data;
                    vofm_pkg::REG_SIZE_X:
                        r_ex <= XW'(clamp_size(int'(i_cfg_data[vofm_pkg::SIZE_X_W-1:0]), MAX_X));
                    vofm_pkg::REG_SIZE_Y:
                        r_ey <= YW'(clamp_size(int'(i_cfg_data[vofm_pkg::SIZE_Y_W-1:0]), MAX_Y));
                    vofm_pkg::REG_SIZE_Z:
                        r_ez <= ZW'(clamp_size(int'(i_cfg_data[vofm_pkg::SIZE_Z_W-1:0]), MAX_Z));
                    default: ;
                endcase
            end
        end
    end

    // stream counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_slot  <= '0;
            r_in_lvl   <= vofm_pkg::LVL_0;
            r_out_x    <= '0;
            r_out_y    <= '0;
            r_out_z    <= '0;
            r_out_slot <= '0;
            r_out_lvl  <= vofm_pkg::LVL_0;
            r_pending  <= '0;
        end else begin
            r_in_slot  <= n_in_slot;
            r_in_lvl   <= n_in_lvl;
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_z    <= n_out_z;
            r_out_slot <= n_out_slot;
            r_out_lvl  <= n_out_lvl;
            r_pending  <= n_pending;
        end
    end

    // two identical copies of the history give four reads per cycle
    vofm_hist_mem #(
        .DEPTH (PLANE),
        .AW    (SW)
    ) u_hist_a (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_in_slot),
        .i_wr_lvl    (r_in_lvl),
        .i_wr_bit    (wr_bit),
        .i_rd_en     (emit),
        .i_rd_addr_a (addr_c),
        .i_rd_addr_b (addr_xp),
        .o_rd_data_a (rd_c),
        .o_rd_data_b (rd_xp)
    );

    vofm_hist_mem #(
        .DEPTH (PLANE),
        .AW    (SW)
    ) u_hist_b (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_in_slot),
        .i_wr_lvl    (r_in_lvl),
        .i_wr_bit    (wr_bit),
        .i_rd_en     (emit),
        .i_rd_addr_a (addr_ym),
        .i_rd_addr_b (addr_yp),
        .o_rd_data_a (rd_ym),
        .o_rd_data_b (rd_yp)
    );

    // mask stage control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (in_acc) begin
            r_s2_valid <= emit;
        end else if (adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s2_x     <= r_out_x;
            r_s2_y     <= r_out_y;
            r_s2_z     <= r_out_z;
            r_s2_lvl   <= r_out_lvl;
            r_s2_force <= s1_force;
            r_s2_last  <= s1_last;
            r_s2_fwd   <= s1_fwd;
            r_s2_wlvl  <= r_in_lvl;
            r_s2_wbit  <= wr_bit;
        end
    end

    assign w_c  = vofm_pkg::lvl_merge(rd_c,  r_s2_fwd[0], r_s2_wlvl, r_s2_wbit);
    assign w_xp = vofm_pkg::lvl_merge(rd_xp, r_s2_fwd[1], r_s2_wlvl, r_s2_wbit);
    assign w_ym = vofm_pkg::lvl_merge(rd_ym, r_s2_fwd[2], r_s2_wlvl, r_s2_wbit);
    assign w_yp = vofm_pkg::lvl_merge(rd_yp, r_s2_fwd[3], r_s2_wlvl, r_s2_wbit);

    // the center word holds the cell and its -z and +z neighbors
    assign s2_sel   = vofm_pkg::lvl_pick(w_c, r_s2_lvl);
    assign s2_nb[0] = r_prev_sel;
    assign s2_nb[1] = vofm_pkg::lvl_pick(w_ym, r_s2_lvl);
    assign s2_nb[2] = vofm_pkg::lvl_pick(w_c, vofm_pkg::lvl_prev(r_s2_lvl));
    assign s2_nb[3] = vofm_pkg::lvl_pick(w_xp, r_s2_lvl);
    assign s2_nb[4] = vofm_pkg::lvl_pick(w_yp, r_s2_lvl);
    assign s2_nb[5] = vofm_pkg::lvl_pick(w_c, vofm_pkg::lvl_next(r_s2_lvl));

    assign s2_face = s2_sel ? (r_s2_force | ~s2_nb) : '0;
    assign s2_mark = s2_sel ? r_interface_color : '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (adv) begin
            r_m_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid) begin
            r_m_data   <= {{vofm_pkg::M_TDATA_PAD{1'b0}}, s2_mark, s2_face,
                           vofm_pkg::CELL_Z_W'(r_s2_z),
                           vofm_pkg::CELL_Y_W'(r_s2_y),
                           vofm_pkg::CELL_X_W'(r_s2_x)};
            r_m_sel    <= s2_sel;
            r_m_last   <= r_s2_last;
            // the next reported cell sees this one as its -x neighbor
            r_prev_sel <= s2_sel;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_sel;
    assign m_axis_tlast  = r_m_last;

endmodule

>>> hw/rtl/vofm_hist_mem.sv
module vofm_hist_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  vofm_pkg::t_lvl          i_wr_lvl,
    input  logic                    i_wr_bit,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr_a,
    input  logic [AW-1:0]           i_rd_addr_b,
    output vofm_pkg::t_lvl_word     o_rd_data_a,
    output vofm_pkg::t_lvl_word     o_rd_data_b
);

    vofm_pkg::t_lvl_word r_mem [DEPTH];
    vofm_pkg::t_lvl_word r_rd_a;
    vofm_pkg::t_lvl_word r_rd_b;
    vofm_pkg::t_lvl_word wr_mask;

    assign wr_mask = vofm_pkg::lvl_onehot(i_wr_lvl);

    // bit-enable write, read-first on both read ports
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int k = 0; k < vofm_pkg::LVL_N; k++) begin
                if (wr_mask[k]) begin
                    r_mem[i_wr_addr][k] <= i_wr_bit;
                end
            end
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vofm_pkg::*;

    // geometry limits of the instance under test
    localparam int MAX_X = 64;
    localparam int MAX_Y = 64;
    localparam int MAX_Z = 4096;

    // selection ring: two planes plus one cell
    localparam int HIST_N = 2 * MAX_X * MAX_Y + 1;

    // cycles without any transaction before the run is declared hung
    localparam int QUIET_LIMIT = 1000;
    // settle time after the last result, covers the two-stage output pipe
    localparam int GUARD_CYCLES = 6;
    localparam int MAX_SHOWN = 10;

    // face mask bit positions
    localparam int FACE_NEG_X = 0;
    localparam int FACE_NEG_Y = 1;
    localparam int FACE_NEG_Z = 2;
    localparam int FACE_POS_X = 3;
    localparam int FACE_POS_Y = 4;
    localparam int FACE_POS_Z = 5;

    // field offsets inside m_axis_tdata
    localparam int OFS_Y = CELL_X_W;
    localparam int OFS_Z = OFS_Y + CELL_Y_W;
    localparam int OFS_M = OFS_Z + CELL_Z_W;
    localparam int OFS_C = OFS_M + FACE_W;

    typedef enum int {PR_NONE, PR_SRC, PR_SINK, PR_BOTH} pressure_kind_t;

    typedef struct packed {
        logic [CELL_X_W-1:0] x;
        logic [CELL_Y_W-1:0] y;
        logic [CELL_Z_W-1:0] z;
        logic                sel;
        logic [FACE_W-1:0]   mask;
        logic [COLOR_W-1:0]  color;
        logic                last;
    } face_report_t;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // label stream into the block
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;   // [15:0] color_value
    logic                   s_axis_tuser  = 1'b0; // [0] cmd

    // face report stream out of the block
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [5:0] cell_x, [11:6] cell_y, [23:12] cell_z, [29:24] face_mask,
    // [45:30] mark_color, [47:46] zero
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;         // [0] cell_selected
    logic                   m_axis_tlast;         // last

    // register write channel
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // handshake pressure, percent of cycles
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // run bookkeeping
    int n_sent;
    int n_checked;
    int n_cfg;
    int n_errors;
    int quiet_cycles;

    // shadow of the block: selection ring, raster walk and registers
    bit                 sel_ring [HIST_N];
    int unsigned        wr_pos;
    int unsigned        n_pending;
    int unsigned        out_x;
    int unsigned        out_y;
    int unsigned        out_z;
    logic [COLOR_W-1:0] sel_color  = '0;
    logic [COLOR_W-1:0] face_color = '0;
    int unsigned        reg_sx     = SIZE_X_RST;
    int unsigned        reg_sy     = SIZE_Y_RST;
    int unsigned        reg_sz     = SIZE_Z_RST;

    // face reports still owed by the block, oldest first
    face_report_t face_reports_due [$];

    voxel_outer_face_marker #(
        .MAX_X(MAX_X),
        .MAX_Y(MAX_Y),
        .MAX_Z(MAX_Z)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial forever #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // face prediction
    // ------------------------------------------------------------------

    // zero acts as one, anything above the limit as the limit
    function automatic int unsigned fit_size(input int unsigned v, input int unsigned lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    // selection bit of the cell received 'back' cells ago
    function automatic bit sel_behind(input int unsigned back);
        return sel_ring[(wr_pos + HIST_N - (back % HIST_N)) % HIST_N];
    endfunction

    // neighbor k cells after the reported one, unselected until it has arrived
    function automatic bit sel_ahead(input int unsigned k);
        if (k >= n_pending) return 1'b0;
        return sel_behind(n_pending - k);
    endfunction

    // oldest pending cell leaves the block: build its report, step the output walk
    task automatic report_next_cell();
        int unsigned  ex;
        int unsigned  ey;
        int unsigned  ez;
        face_report_t r;
        ex = fit_size(reg_sx, MAX_X);
        ey = fit_size(reg_sy, MAX_Y);
        ez = fit_size(reg_sz, MAX_Z);
        r = '0;
        r.sel = sel_behind(n_pending);
        if (r.sel) begin
            // a face counts when it is on the grid edge or the neighbor is unselected
            r.mask[FACE_NEG_X] = (out_x == 0) || !sel_behind(n_pending + 1);
            r.mask[FACE_NEG_Y] = (out_y == 0) || !sel_behind(n_pending + ex);
            r.mask[FACE_NEG_Z] = (out_z == 0) || !sel_behind(n_pending + ex * ey);
            r.mask[FACE_POS_X] = (out_x >= ex - 1) || !sel_ahead(1);
            r.mask[FACE_POS_Y] = (out_y >= ey - 1) || !sel_ahead(ex);
            r.mask[FACE_POS_Z] = (out_z >= ez - 1) || !sel_ahead(ex * ey);
            r.color = face_color;
        end
        r.x    = CELL_X_W'(out_x);
        r.y    = CELL_Y_W'(out_y);
        r.z    = CELL_Z_W'(out_z);
        r.last = (out_x >= ex - 1) && (out_y >= ey - 1) && (out_z >= ez - 1);
        face_reports_due.push_back(r);

        // raster walk wraps into the next volume
        if (++out_x >= ex) begin
            out_x = 0;
            if (++out_y >= ey) begin
                out_y = 0;
                if (++out_z >= ez) out_z = 0;
            end
        end
        n_pending--;
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one transaction on the label stream; valid stays up for a following item
    task automatic send_item(input logic cmd, input logic [COLOR_W-1:0] color);
        int unsigned plane;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= color;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;

        plane = fit_size(reg_sx, MAX_X) * fit_size(reg_sy, MAX_Y);
        if (cmd == CMD_FLUSH) begin
            // a flush only reports when something is pending
            if (n_pending != 0) report_next_cell();
        end else begin
            sel_ring[wr_pos] = (color == sel_color);
            wr_pos = (wr_pos + 1) % HIST_N;
            if (n_pending <= plane) n_pending++;
            // the +z neighbor has arrived: one plane behind gets reported
            if (n_pending > plane) report_next_cell();
        end
    endtask

    // one transaction on the register channel, then valid drops before the task returns
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg++;
        case (idx)
            REG_SELECT_COLOR:    sel_color  = COLOR_W'(val);
            REG_INTERFACE_COLOR: face_color = COLOR_W'(val);
            REG_SIZE_X:          reg_sx     = val % (1 << SIZE_X_W);
            REG_SIZE_Y:          reg_sy     = val % (1 << SIZE_Y_W);
            REG_SIZE_Z:          reg_sz     = val % (1 << SIZE_Z_W);
            default: ;
        endcase
        // size writes restart the raster walk and drop whatever is pending
        if (idx == REG_SIZE_X || idx == REG_SIZE_Y || idx == REG_SIZE_Z) begin
            wr_pos    = 0;
            n_pending = 0;
            out_x     = 0;
            out_y     = 0;
            out_z     = 0;
        end
        @(posedge i_clk);
    endtask

    // sender holds off until every owed report has come out
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (face_reports_due.size() != 0);
    endtask

    // drained, then a guard wait for cells that are still in the pipe
    task automatic settle();
        wait_drain();
        repeat (GUARD_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned sel, input int unsigned iface,
                             input int unsigned sx, input int unsigned sy,
                             input int unsigned sz);
        settle();
        write_reg(REG_SELECT_COLOR, sel);
        write_reg(REG_INTERFACE_COLOR, iface);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
    endtask

    task automatic set_pressure(input pressure_kind_t kind);
        case (kind)
            PR_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            PR_SRC:  begin src_idle_pct = 47; sink_stall_pct = 0;  end
            PR_SINK: begin src_idle_pct = 0;  sink_stall_pct = 47; end
            default: begin src_idle_pct = 30; sink_stall_pct = 30; end
        endcase
    endtask

    // mostly the selected color, some one-bit neighbors of it, some anything
    function automatic logic [COLOR_W-1:0] pick_color();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return sel_color;
        if (r < 85) return sel_color ^ (16'd1 << $urandom_range(COLOR_W - 1));
        return COLOR_W'($urandom());
    endfunction

    task automatic send_random(input int n, input int flush_pct);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < flush_pct)
                send_item(CMD_FLUSH, COLOR_W'($urandom()));
            else
                send_item(CMD_CELL, pick_color());
        end
    endtask

    task automatic flush_all();
        while (n_pending != 0) send_item(CMD_FLUSH, COLOR_W'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // 3x2x2 volume with extreme colors, flushes on an empty block at both ends
    task automatic test_directed_volume();
        logic [COLOR_W-1:0] cols [12];
        set_pressure(PR_NONE);
        configure(16'h8000, 16'h7FFF, 3, 2, 2);
        cols = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                 16'h8000, 16'h8000, 16'h0000, 16'hFFFF, 16'h8000, 16'h8000};
        send_item(CMD_FLUSH, 16'hFFFF);
        foreach (cols[i]) send_item(CMD_CELL, cols[i]);
        // top plane goes out before its +z neighbors ever arrive
        flush_all();
        send_item(CMD_FLUSH, 16'h0000);
    endtask

    // select color changes with cells pending: stored bits keep their value
    task automatic test_select_change();
        set_pressure(PR_BOTH);
        configure(16'h7FFF, 16'h8000, 2, 1, 2);
        send_item(CMD_CELL, 16'h7FFF);
        send_item(CMD_CELL, 16'h7FFF);
        settle();
        write_reg(REG_SELECT_COLOR, 16'h0000);
        send_item(CMD_CELL, 16'h0000);
        send_item(CMD_CELL, 16'h7FFF);
        settle();
        write_reg(REG_INTERFACE_COLOR, 16'h5A5A);
        flush_all();
    endtask

    // a size write drops pending cells and restarts coordinates
    task automatic test_restart();
        set_pressure(PR_SRC);
        configure(16'h0F0F, 16'hF0F0, 2, 1, 2);
        send_item(CMD_CELL, 16'h0F0F);
        send_item(CMD_CELL, 16'h0F0F);
        settle();
        write_reg(REG_SIZE_Z, 3);
        send_item(CMD_FLUSH, 16'h0F0F);
        send_random(4, 0);
        flush_all();
    endtask

    // zero and oversized sizes, full x and y lines, the deepest z walk
    task automatic test_size_extremes();
        set_pressure(PR_SINK);
        configure($urandom(), $urandom(), 0, 0, 0);
        send_random(12, 20);
        flush_all();

        set_pressure(PR_SRC);
        configure($urandom(), $urandom(), 127, 1, 2);
        send_random(2 * MAX_X, 5);
        flush_all();

        set_pressure(PR_BOTH);
        configure($urandom(), $urandom(), 1, MAX_Y, 2);
        send_random(2 * MAX_Y, 5);
        flush_all();

        // one cell per plane, oversized depth clamps to the maximum, then wraps
        set_pressure(PR_NONE);
        configure($urandom(), $urandom(), 1, 1, 8191);
        send_random(MAX_Z + 1, 0);
        flush_all();
    endtask

    // random small volumes back to back, random flushes, all pressure modes
    task automatic test_random_volumes();
        int unsigned sx;
        int unsigned sy;
        int unsigned sz;
        for (int seg = 0; seg < 8; seg++) begin
            set_pressure(pressure_kind_t'(seg % 4));
            sx = $urandom_range(6, 0);
            sy = $urandom_range(6, 0);
            sz = $urandom_range(6, 0);
            // now and then one long or deep dimension, plane kept small
            case ($urandom_range(5, 0))
                0: begin sx = $urandom_range(127, 7); sy = $urandom_range(2, 0); end
                1: begin sy = $urandom_range(127, 7); sx = $urandom_range(2, 0); end
                2: sz = $urandom_range(8191, 7);
                default: ;
            endcase
            configure($urandom(), $urandom(), sx, sy, sz);
            send_random(28, 12);
            // sender holds off mid-stream until everything owed is out
            if (seg == 2) wait_drain();
            send_random(28, 12);
            if (seg % 2 == 1) flush_all();
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic log_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_SHOWN) $display("error: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            log_error($sformatf("result %0d %s expected 0x%0h got 0x%0h",
                                n_checked, name, want, got));
    endtask

    // every report transaction is matched against the oldest owed report
    always @(posedge i_clk) begin : check_reports
        face_report_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_checked++;
            if (face_reports_due.size() == 0) begin
                log_error($sformatf("result %0d arrived with nothing owed", n_checked));
            end else begin
                want = face_reports_due.pop_front();
                check_field("cell_x", want.x, m_axis_tdata[0 +: CELL_X_W]);
                check_field("cell_y", want.y, m_axis_tdata[OFS_Y +: CELL_Y_W]);
                check_field("cell_z", want.z, m_axis_tdata[OFS_Z +: CELL_Z_W]);
                check_field("face_mask", want.mask, m_axis_tdata[OFS_M +: FACE_W]);
                check_field("mark_color", want.color, m_axis_tdata[OFS_C +: COLOR_W]);
                check_field("tdata padding", 0, m_axis_tdata[M_TDATA_W-1 -: M_TDATA_PAD]);
                check_field("cell_selected", want.sel, m_axis_tuser);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // receiver stalls at random according to the current pressure mode
    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    // hang detection: any transaction on any channel resets the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d reports owed",
                     quiet_cycles, face_reports_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_volume();
        test_select_change();
        test_restart();
        test_size_extremes();
        test_random_volumes();

        // everything owed must come out, then nothing more may follow
        settle();

        $display("summary: %0d label transactions, %0d face reports checked, %0d register writes",
                 n_sent, n_checked, n_cfg);
        $display("summary: cells and flushes over sizes 1x1x1 to 64-long lines and 4096 planes, %s",
                 "select changes mid-stream, restarts, four handshake pressure modes");
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches in total", n_errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/vofm_pkg.sv
hw/rtl/vofm_hist_mem.sv
hw/rtl/voxel_outer_face_marker.sv
tb/testbench.sv
